### sv/bs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bs_pkg: shared types for the bubble sorter
// Beat layouts of the input and result channels.
// ----------------------------------------------------------------------------
package bs_pkg;

  localparam int VALUE_W = 32;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } in_beat_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      final_res;
    logic                      dropped;
  } out_beat_t;

endpackage

### sv/bs_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bs_engine: element store and sort sequencer
// Collects a set into a synchronous RAM, sorts it in place with bubble passes
// that carry the running larger value in a register, then reads it out.
// ----------------------------------------------------------------------------
module bs_engine
  import bs_pkg::*;
#(
  parameter int MAX_ELEMENTS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_beat,
  output logic      push_valid,
  input  logic      push_ready,
  output out_beat_t push_beat
);

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CW-1:0] CAP = CW'(MAX_ELEMENTS);
  localparam logic [CW-1:0] ONE = CW'(1);
  localparam logic [CW-1:0] TWO = CW'(2);

  typedef enum logic [2:0] {
    S_COLLECT,
    S_P_START,
    S_P_FIRST,
    S_P_STEP,
    S_P_END,
    S_E_RD,
    S_E_PUSH
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] m_r, m_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic signed [VALUE_W-1:0] carry_r, carry_nxt;

  // RAM, one write and one read port, registered read data
  logic signed [VALUE_W-1:0] mem [MAX_ELEMENTS];
  logic signed [VALUE_W-1:0] rd_data_r;
  logic                      mem_we, mem_re;
  logic [AW-1:0]             mem_wa, mem_ra;
  logic signed [VALUE_W-1:0] mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  logic          full;
  logic [CW-1:0] cnt_new;
  logic [CW-1:0] k_inc;
  logic [CW-1:0] k_dec;
  logic [CW-1:0] m_dec;
  logic          swap;

  assign full    = (count_r == CAP);
  assign cnt_new = full ? count_r : count_r + ONE;
  assign k_inc   = k_r + ONE;
  assign k_dec   = k_r - ONE;
  assign m_dec   = m_r - ONE;
  assign swap    = carry_r > rd_data_r;

  assign in_ready   = (state_r == S_COLLECT);
  assign push_valid = (state_r == S_E_PUSH);
  assign push_beat.sorted_value = rd_data_r;
  assign push_beat.final_res    = (k_inc == count_r);
  assign push_beat.dropped      = ovf_r;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    m_nxt     = m_r;
    k_nxt     = k_r;
    carry_nxt = carry_r;
    mem_we    = 1'b0;
    mem_wa    = count_r[AW-1:0];
    mem_wd    = in_beat.value;
    mem_re    = 1'b0;
    mem_ra    = k_r[AW-1:0];
    case (state_r)
      S_COLLECT: begin
        if (in_valid) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            mem_we = 1'b1;
          end
          count_nxt = cnt_new;
          if (in_beat.last) begin
            m_nxt = cnt_new;
            k_nxt = '0;
            state_nxt = (cnt_new >= TWO) ? S_P_START : S_E_RD;
          end
        end
      end
      S_P_START: begin
        mem_re    = 1'b1;
        mem_ra    = '0;
        k_nxt     = ONE;
        state_nxt = S_P_FIRST;
      end
      S_P_FIRST: begin
        // first element of the pass becomes the carry
        carry_nxt = rd_data_r;
        mem_re    = 1'b1;
        state_nxt = S_P_STEP;
      end
      S_P_STEP: begin
        // drop the smaller one behind, keep the larger in the carry
        mem_we = 1'b1;
        mem_wa = k_dec[AW-1:0];
        if (swap) begin
          mem_wd = rd_data_r;
        end else begin
          mem_wd    = carry_r;
          carry_nxt = rd_data_r;
        end
        if (k_inc < m_r) begin
          mem_re = 1'b1;
          mem_ra = k_inc[AW-1:0];
          k_nxt  = k_inc;
        end else begin
          state_nxt = S_P_END;
        end
      end
      S_P_END: begin
        mem_we = 1'b1;
        mem_wa = m_dec[AW-1:0];
        mem_wd = carry_r;
        m_nxt  = m_dec;
        k_nxt  = '0;
        state_nxt = (m_dec >= TWO) ? S_P_START : S_E_RD;
      end
      S_E_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_E_PUSH;
      end
      S_E_PUSH: begin
        if (push_ready) begin
          if (k_inc == count_r) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_COLLECT;
          end else begin
            k_nxt     = k_inc;
            state_nxt = S_E_RD;
          end
        end
      end
      default: begin
        state_nxt = S_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_COLLECT;
      count_r <= '0;
      ovf_r   <= 1'b0;
      m_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      m_r     <= m_nxt;
      k_r     <= k_nxt;
    end
    carry_r <= carry_nxt;
  end

endmodule

### sv/bs_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bs_out_reg: result output register
// Holds one result beat so the engine can move on while the receiver stalls.
// ----------------------------------------------------------------------------
module bs_out_reg
  import bs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  out_beat_t push_beat,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_beat
);

  logic      valid_r;
  out_beat_t beat_r;

  assign push_ready = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_beat   = beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push_ready) begin
      valid_r <= push_valid;
    end
    // load a new beat only when the slot is free or being drained
    if (push_ready && push_valid) begin
      beat_r <= push_beat;
    end
  end

endmodule

### sv/bubble_sorter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bubble_sorter: ascending sort of a set of signed 32-bit values
// Input beats carry one value each; the beat with last set closes the set.
// After the closing beat, the set is sorted in place in a single-port-read
// RAM by bubble passes and streamed out as one result beat per element,
// with final_res on the last and dropped on every beat of a set in which
// values beyond MAX_ELEMENTS were ignored. Equal values keep arrival order.
// Collecting accepts one input beat per cycle. Each pass over m elements
// reads the elements one by one after a pass setup and ends with a final
// write of the carry; passes run for m = n down to 2, where n is the
// stored count. Readout reads each element from the RAM, then hands it off.
// in_ready is high only while collecting. The output register holds a
// result while out_ready is low and stalls readout; the next set can be
// collected while the final result still waits. Reset empties the set.
// ----------------------------------------------------------------------------
module bubble_sorter
  import bs_pkg::*;
#(
  parameter int MAX_ELEMENTS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_beat
);

  logic      push_valid;
  logic      push_ready;
  out_beat_t push_beat;

  bs_engine #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_beat (push_beat)
  );

  bs_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_beat (push_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

endmodule

### dv/bubble_sorter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bubble_sorter_tb: self-checking testbench for the bubble sorter
// Sends sets of signed values through the input channel, keeps its own
// sorted copy of every set and checks each result beat against it in order.
// The sender idles in bursts, the receiver stalls in changing modes.
// ----------------------------------------------------------------------------
module bubble_sorter_tb;
  import bs_pkg::*;

  localparam int SET_CAP     = 16;
  localparam int ITEM_TARGET = 364;
  localparam int MAX_REPORTS = 10;

  typedef logic signed [VALUE_W-1:0] elem_t;
  typedef elem_t elem_q_t[$];
  typedef enum int {RX_STEADY, RX_CHOPPY, RX_SPARSE} rx_mode_t;
  typedef enum int {VAL_ANY, VAL_NEAR_ZERO, VAL_EDGES} val_kind_t;

  localparam elem_t VAL_MIN = 32'sh8000_0000;
  localparam elem_t VAL_MAX = 32'sh7FFF_FFFF;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_beat;

  // predictor state: the set being collected
  elem_t       set_store [SET_CAP];
  int unsigned set_count    = 0;
  bit          set_overflow = 1'b0;
  out_beat_t   sorted_expect_q[$];

  int       error_count = 0;
  int       burst_left  = 0;
  int       items_sent  = 0;
  rx_mode_t rx_mode     = RX_STEADY;
  int       mode_left   = 0;

  bubble_sorter #(.MAX_ELEMENTS(SET_CAP)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

  always #6 clk = ~clk;

  // Store one accepted value; on the closing beat sort the set and queue
  // one expected result per stored element.
  function automatic void absorb_value(input in_beat_t beat);
    elem_t     tmp;
    out_beat_t res;
    if (set_count < SET_CAP) begin
      set_store[set_count] = beat.value;
      set_count++;
    end else begin
      set_overflow = 1'b1;
    end
    if (beat.last) begin
      // swap only strictly greater pairs, so ties keep arrival order
      for (int pass = 0; pass + 1 < set_count; pass++) begin
        for (int k = 0; k + 1 < set_count - pass; k++) begin
          if (set_store[k] > set_store[k+1]) begin
            tmp            = set_store[k];
            set_store[k]   = set_store[k+1];
            set_store[k+1] = tmp;
          end
        end
      end
      for (int k = 0; k < set_count; k++) begin
        res.sorted_value = set_store[k];
        res.final_res    = (k + 1 == set_count);
        res.dropped      = set_overflow;
        sorted_expect_q.push_back(res);
      end
      set_count    = 0;
      set_overflow = 1'b0;
    end
  endfunction

  function automatic elem_t pick_value(input val_kind_t kind);
    case (kind)
      VAL_NEAR_ZERO: return elem_t'($urandom_range(0, 10)) - 5;
      VAL_EDGES: begin
        case ($urandom_range(0, 4))
          0:       return VAL_MIN;
          1:       return VAL_MAX;
          2:       return -1;
          3:       return 1;
          default: return 0;
        endcase
      end
      default: return elem_t'($urandom);
    endcase
  endfunction

  // Send one beat; open a gap first when the current burst is used up.
  task automatic send_value(input elem_t value, input logic is_last);
    in_beat_t beat;
    beat.value = value;
    beat.last  = is_last;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90)
                                               : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_beat  <= beat;
    do @(posedge clk); while (!in_ready);
    absorb_value(beat);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_set(input elem_q_t vals);
    foreach (vals[i]) send_value(vals[i], i == vals.size() - 1);
  endtask

  // Hold the sender until every queued result has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sorted_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_single_element();
    send_set('{VAL_MIN});
    send_set('{VAL_MAX});
  endtask

  task automatic test_extremes_and_ties();
    send_set('{VAL_MAX, VAL_MIN, 0, -1, 1, VAL_MAX});
  endtask

  // Descending run of SET_CAP + 1 values: the closing beat itself is dropped.
  task automatic test_overflow_on_last();
    elem_q_t vals;
    for (int i = SET_CAP + 1; i > 0; i--) vals.push_back(elem_t'(i));
    send_set(vals);
  endtask

  task automatic test_drain_pause();
    wait_drained();
    repeat ($urandom_range(1, 20)) @(posedge clk);
  endtask

  task automatic test_random_sets();
    elem_q_t   vals;
    val_kind_t kind;
    int        size;
    int        pick;
    bit        paused = 1'b0;
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)      size = $urandom_range(1, 5);
      else if (pick < 85) size = $urandom_range(6, SET_CAP);
      else                size = $urandom_range(SET_CAP + 1, SET_CAP + 6);
      kind = val_kind_t'($urandom_range(0, 2));
      vals.delete();
      repeat (size) vals.push_back(pick_value(kind));
      send_set(vals);
      if (!paused && items_sent > ITEM_TARGET / 2) begin
        test_drain_pause();
        paused = 1'b1;
      end
    end
  endtask

  // Receiver: switch between steady, choppy and mostly stalled modes.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      mode_left <= $urandom_range(20, 150);
      rx_mode   <= rx_mode_t'($urandom_range(0, 2));
    end else begin
      mode_left <= mode_left - 1;
    end
    case (rx_mode)
      RX_STEADY: out_ready <= 1'b1;
      RX_CHOPPY: out_ready <= 1'($urandom_range(0, 1));
      default:   out_ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (sorted_expect_q.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: unexpected result beat value=%0d final=%b dropped=%b",
                   $realtime, out_beat.sorted_value, out_beat.final_res,
                   out_beat.dropped);
      end else begin
        want = sorted_expect_q.pop_front();
        if (out_beat.sorted_value !== want.sorted_value ||
            out_beat.final_res !== want.final_res ||
            out_beat.dropped !== want.dropped) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: mismatch exp %0d/%b/%b got %0d/%b/%b",
                     $realtime, want.sorted_value, want.final_res, want.dropped,
                     out_beat.sorted_value, out_beat.final_res, out_beat.dropped);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_element();
    test_extremes_and_ties();
    test_overflow_on_last();
    test_drain_pause();
    test_random_sets();
    wait_drained();
    repeat (40) @(posedge clk);
    if (sorted_expect_q.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
